[src/tcmp_pkg.sv]
// shared types and constants of the tone command motor pwm block
package tcmp_pkg;

    localparam int RATE_W   = 27;
    localparam int FREQ_W   = 16;
    localparam int TOL_W    = 12;
    localparam int EDGE_W   = 17;
    localparam int PSAT_W   = 28;
    localparam int PROD_W   = 45;
    localparam int PWM_W    = 8;
    localparam int PER_W    = 32;
    localparam int CMD_W    = 3;
    localparam int CIDX_W   = 3;
    localparam int BANDS    = 4;

    localparam logic [PSAT_W-1:0] PERIOD_SAT = 28'h800_0000;
    localparam logic [PWM_W-1:0]  DUTY_ON    = 8'd99;
    localparam logic [PWM_W-1:0]  DUTY_OFF   = 8'd0;
    localparam logic [PWM_W-1:0]  AUX_LEVEL  = 8'd80;

    localparam logic [FREQ_W-1:0] RIGHT_RST    = 16'd14550;
    localparam logic [FREQ_W-1:0] FORWARD_RST  = 16'd15000;
    localparam logic [FREQ_W-1:0] BACKWARD_RST = 16'd14650;
    localparam logic [FREQ_W-1:0] LEFT_RST     = 16'd15150;
    localparam logic [TOL_W-1:0]  TOL_RST      = 12'd50;
    localparam logic [RATE_W-1:0] RATE_RST     = 27'd6000000;

    typedef enum logic [CIDX_W-1:0] {
        CFG_RIGHT    = 3'd0,
        CFG_FORWARD  = 3'd1,
        CFG_BACKWARD = 3'd2,
        CFG_LEFT     = 3'd3,
        CFG_TOL      = 3'd4,
        CFG_RATE     = 3'd5
    } cfg_idx_t;

    typedef enum logic [CMD_W-1:0] {
        CMD_STOP     = 3'd0,
        CMD_RIGHT    = 3'd1,
        CMD_FORWARD  = 3'd2,
        CMD_BACKWARD = 3'd3,
        CMD_LEFT     = 3'd4
    } cmd_t;

    // one tick after measurement and pwm update
    typedef struct packed {
        logic [PWM_W-1:0]  pwm;
        logic              done;
        logic [PER_W-1:0]  period;
        logic [PSAT_W-1:0] period_sat;
    } item_t;

    typedef struct packed {
        logic  valid;
        item_t item;
    } push_t;

    // duty enables in order right a, right b, left a, left b
    function automatic logic [3:0] duty_on(cmd_t c);
        logic [3:0] r;
        case (c)
            CMD_RIGHT:    r = 4'b1010;
            CMD_FORWARD:  r = 4'b1001;
            CMD_BACKWARD: r = 4'b0110;
            CMD_LEFT:     r = 4'b0101;
            default:      r = 4'b0000;
        endcase
        return r;
    endfunction

endpackage

[src/tcmp_front.sv]
// front end: tick acceptance, period measurement and pwm counter
module tcmp_front #(
    parameter int COUNT_WIDTH = 32,
    parameter int PWM_TOP     = 100
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  logic           s_signal_level,
    input  logic           s_pwm_tick,
    output tcmp_pkg::push_t push,
    input  logic           q_full
);
    import tcmp_pkg::*;

    localparam int PW = $clog2(PWM_TOP + 1);
    localparam logic [PW-1:0] PWM_TOP_C = PW'(PWM_TOP);

    typedef enum logic [1:0] {
        PH_WAIT_LOW   = 2'd0,
        PH_WAIT_HIGH  = 2'd1,
        PH_COUNT_HIGH = 2'd2,
        PH_COUNT_LOW  = 2'd3
    } phase_t;

    phase_t                 phase_reg, phase_next;
    logic [COUNT_WIDTH-1:0] count_reg, count_next, count_inc;
    logic [COUNT_WIDTH-1:0] last_reg, last_next;
    logic [PW-1:0]          pwm_reg, pwm_next;
    logic                   done;
    logic                   accept;
    logic                   sat;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;

    assign count_inc = (count_reg == '1) ? count_reg : count_reg + 1'b1;

    always_comb begin
        phase_next = phase_reg;
        count_next = count_reg;
        last_next  = last_reg;
        done       = 1'b0;
        case (phase_reg)
            PH_WAIT_LOW: begin
                if (!s_signal_level) phase_next = PH_WAIT_HIGH;
            end
            PH_WAIT_HIGH: begin
                if (s_signal_level) begin
                    count_next = '0;
                    phase_next = PH_COUNT_HIGH;
                end
            end
            PH_COUNT_HIGH: begin
                count_next = count_inc;
                if (!s_signal_level) phase_next = PH_COUNT_LOW;
            end
            PH_COUNT_LOW: begin
                count_next = count_inc;
                if (s_signal_level) begin
                    last_next  = count_inc;
                    done       = 1'b1;
                    phase_next = PH_WAIT_LOW;
                end
            end
            default: phase_next = PH_WAIT_LOW;
        endcase
    end

    always_comb begin
        pwm_next = pwm_reg;
        if (s_pwm_tick) pwm_next = (pwm_reg == PWM_TOP_C) ? '0 : pwm_reg + 1'b1;
    end

    // periods of 2^27 ticks or more all classify alike
    assign sat = ((COUNT_WIDTH + PSAT_W)'(last_next) >= (COUNT_WIDTH + PSAT_W)'(PERIOD_SAT));

    always_comb begin
        push.valid           = accept;
        push.item.pwm        = PWM_W'(pwm_next);
        push.item.done       = done;
        push.item.period     = PER_W'(last_next);
        push.item.period_sat = sat ? PERIOD_SAT : PSAT_W'(last_next);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_WAIT_LOW;
            count_reg <= '0;
            last_reg  <= '0;
            pwm_reg   <= '0;
        end else if (accept) begin
            phase_reg <= phase_next;
            count_reg <= count_next;
            last_reg  <= last_next;
            pwm_reg   <= pwm_next;
        end
    end

endmodule

[src/tcmp_queue.sv]
// short queue between front and back end
module tcmp_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  tcmp_pkg::push_t push,
    output logic            full,
    output logic            pop_valid,
    input  logic            pop_ready,
    output tcmp_pkg::item_t pop_item
);
    import tcmp_pkg::*;

    localparam int DEPTH = 4;
    localparam int AW    = $clog2(DEPTH);

    item_t         mem_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [AW:0]   cnt_reg, cnt_next;
    logic          do_push, do_pop;

    assign full      = (cnt_reg == (AW + 1)'(DEPTH));
    assign pop_valid = (cnt_reg != '0);
    assign pop_item  = mem_reg[rd_ptr_reg];
    assign do_push   = push.valid && !full;
    assign do_pop    = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push && !do_pop) cnt_next = cnt_reg + 1'b1;
        else if (!do_push && do_pop) cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) mem_reg[wr_ptr_reg] <= push.item;
    end

endmodule

[src/tcmp_back.sv]
// back end: band classification, command register and drive outputs
module tcmp_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          pop_valid,
    output logic                          pop_ready,
    input  tcmp_pkg::item_t               pop_item,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [tcmp_pkg::CIDX_W-1:0]   cfg_index,
    input  logic [tcmp_pkg::RATE_W-1:0]   cfg_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_right_drive_a,
    output logic                          m_right_drive_b,
    output logic                          m_left_drive_a,
    output logic                          m_left_drive_b,
    output logic                          m_aux_drive,
    output logic [2:0]                    m_active_command,
    output logic                          m_measure_done,
    output logic [31:0]                   m_period_ticks
);
    import tcmp_pkg::*;

    // configuration
    logic [FREQ_W-1:0] center_reg [BANDS];
    logic [TOL_W-1:0]  tol_reg;
    logic [RATE_W-1:0] rate_reg;
    logic [FREQ_W-1:0] lo_reg [BANDS];
    logic [EDGE_W-1:0] hi_reg [BANDS];

    // multiply stage
    logic              v1_reg, v1_next;
    item_t             item1_reg;
    logic [PROD_W-1:0] lprod_reg [BANDS];
    logic [PROD_W-1:0] hprod_reg [BANDS];

    // output stage
    logic              m_valid_reg, m_valid_next;
    cmd_t              cmd_reg, cmd_next, cmd_sel;
    logic [3:0]        drive_reg, drive_next;
    logic              aux_reg, aux_next;
    logic              done_reg;
    logic [PER_W-1:0]  period_reg;

    logic              out_free, s1_free;
    logic [BANDS-1:0]  band_ok;
    logic [3:0]        on;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            center_reg[0] <= RIGHT_RST;
            center_reg[1] <= FORWARD_RST;
            center_reg[2] <= BACKWARD_RST;
            center_reg[3] <= LEFT_RST;
            tol_reg       <= TOL_RST;
            rate_reg      <= RATE_RST;
        end else if (cfg_valid) begin
            case (cfg_idx_t'(cfg_index))
                CFG_RIGHT:    center_reg[0] <= cfg_data[FREQ_W-1:0];
                CFG_FORWARD:  center_reg[1] <= cfg_data[FREQ_W-1:0];
                CFG_BACKWARD: center_reg[2] <= cfg_data[FREQ_W-1:0];
                CFG_LEFT:     center_reg[3] <= cfg_data[FREQ_W-1:0];
                CFG_TOL:      tol_reg       <= cfg_data[TOL_W-1:0];
                CFG_RATE:     rate_reg      <= cfg_data;
                default: ;
            endcase
        end
    end

    // band edges, lower edge floored at zero
    always_ff @(posedge aclk) begin
        for (int i = 0; i < BANDS; i++) begin
            lo_reg[i] <= (center_reg[i] > FREQ_W'(tol_reg))
                       ? center_reg[i] - FREQ_W'(tol_reg) : '0;
            hi_reg[i] <= EDGE_W'(center_reg[i]) + EDGE_W'(tol_reg);
        end
    end

    assign out_free  = !m_valid_reg || m_ready;
    assign s1_free   = !v1_reg || out_free;
    assign pop_ready = s1_free;

    assign v1_next = s1_free ? pop_valid : v1_reg;

    always_ff @(posedge aclk) begin
        if (s1_free) begin
            item1_reg <= pop_item;
            for (int i = 0; i < BANDS; i++) begin
                lprod_reg[i] <= PROD_W'(lo_reg[i]) * PROD_W'(pop_item.period_sat);
                hprod_reg[i] <= PROD_W'(hi_reg[i]) * PROD_W'(pop_item.period_sat);
            end
        end
    end

    always_comb begin
        for (int i = 0; i < BANDS; i++) begin
            band_ok[i] = (lprod_reg[i] <= PROD_W'(rate_reg))
                      && (hprod_reg[i] >= PROD_W'(rate_reg));
        end
        if (band_ok[0])      cmd_sel = CMD_RIGHT;
        else if (band_ok[1]) cmd_sel = CMD_FORWARD;
        else if (band_ok[2]) cmd_sel = CMD_BACKWARD;
        else if (band_ok[3]) cmd_sel = CMD_LEFT;
        else                 cmd_sel = CMD_STOP;
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        cmd_next     = cmd_reg;
        if (out_free) begin
            m_valid_next = v1_reg;
            if (v1_reg && item1_reg.done) cmd_next = cmd_sel;
        end
        on = duty_on(cmd_next);
        for (int i = 0; i < 4; i++) begin
            drive_next[i] = (item1_reg.pwm <= (on[3-i] ? DUTY_ON : DUTY_OFF));
        end
        aux_next = (item1_reg.pwm <= AUX_LEVEL);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
            cmd_reg     <= CMD_STOP;
        end else begin
            v1_reg      <= v1_next;
            m_valid_reg <= m_valid_next;
            cmd_reg     <= cmd_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free && v1_reg) begin
            drive_reg  <= drive_next;
            aux_reg    <= aux_next;
            done_reg   <= item1_reg.done;
            period_reg <= item1_reg.period;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_right_drive_a  = drive_reg[0];
    assign m_right_drive_b  = drive_reg[1];
    assign m_left_drive_a   = drive_reg[2];
    assign m_left_drive_b   = drive_reg[3];
    assign m_aux_drive      = aux_reg;
    assign m_active_command = cmd_reg;
    assign m_measure_done   = done_reg;
    assign m_period_ticks   = period_reg;

endmodule

[src/tone_command_motor_pwm_top.sv]
// top level of the tone command motor pwm block
// an accepted tick runs through the queue, multiply stage and output stage to m_
// throughput: one transaction per cycle unless m_ready stalls, set by front, queue
// and two back stages; the four bands' edge multiplies all sit in one multiply stage
// reset: synchronous active-low aresetn clears phase, counters, command and queue
// configuration registers return to their default band settings on reset
module tone_command_motor_pwm_top #(
    parameter int COUNT_WIDTH = 32,
    parameter int PWM_TOP     = 100
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic                        s_signal_level,
    input  logic                        s_pwm_tick,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic                        m_right_drive_a,
    output logic                        m_right_drive_b,
    output logic                        m_left_drive_a,
    output logic                        m_left_drive_b,
    output logic                        m_aux_drive,
    output logic [2:0]                  m_active_command,
    output logic                        m_measure_done,
    output logic [31:0]                 m_period_ticks,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [tcmp_pkg::CIDX_W-1:0] cfg_index,
    input  logic [tcmp_pkg::RATE_W-1:0] cfg_data
);
    import tcmp_pkg::*;

    push_t push;
    logic  q_full;
    logic  pop_valid, pop_ready;
    item_t pop_item;

    tcmp_front #(
        .COUNT_WIDTH (COUNT_WIDTH),
        .PWM_TOP     (PWM_TOP)
    ) u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_signal_level (s_signal_level),
        .s_pwm_tick     (s_pwm_tick),
        .push           (push),
        .q_full         (q_full)
    );

    tcmp_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .full      (q_full),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_item  (pop_item)
    );

    tcmp_back u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .pop_valid        (pop_valid),
        .pop_ready        (pop_ready),
        .pop_item         (pop_item),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_right_drive_a  (m_right_drive_a),
        .m_right_drive_b  (m_right_drive_b),
        .m_left_drive_a   (m_left_drive_a),
        .m_left_drive_b   (m_left_drive_b),
        .m_aux_drive      (m_aux_drive),
        .m_active_command (m_active_command),
        .m_measure_done   (m_measure_done),
        .m_period_ticks   (m_period_ticks)
    );

endmodule

[src/tcmp_checker.sv]
// port-level checker for the tone command motor pwm top level, with its bind
module tcmp_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic        m_right_drive_a,
    input logic        m_right_drive_b,
    input logic        m_left_drive_a,
    input logic        m_left_drive_b,
    input logic        m_aux_drive,
    input logic [2:0]  m_active_command,
    input logic        m_measure_done,
    input logic [31:0] m_period_ticks
);

    // no result right after reset
    a_reset_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !$past(aresetn) |-> !m_valid)
        else $error("result offered right after reset");

    // stalled result transaction holds its period, command and done flag
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_period_ticks)
            && $stable(m_active_command) && $stable(m_measure_done))
        else $error("stalled result changed");

    a_cmd_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_active_command <= 3'd4))
        else $error("command code out of range");

    // both bridge inputs of one motor on only at counter zero, checked here as aux drive on
    a_bridge: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && ((m_right_drive_a && m_right_drive_b) || (m_left_drive_a && m_left_drive_b))
            |-> m_aux_drive)
        else $error("bridge shoot-through outside counter zero");

endmodule

bind tone_command_motor_pwm_top tcmp_checker u_tcmp_checker (.*);

[bench/tb_top.sv]
// self-checking bench for the tone command motor pwm block: directed table then random waveforms
module tb_top;
    import tcmp_pkg::*;

    localparam int CNT_W       = 32;
    localparam int PWM_MAX     = 100;
    localparam int PWM_ON      = 99;
    localparam int AUX_AT      = 80;
    localparam int QUIET_LIMIT = 4000;
    localparam int HOLD_CYCLES = 150;
    localparam int TAIL_CYCLES = 10;

    typedef enum logic [1:0] {
        WAIT_LOW, WAIT_HIGH, COUNT_HIGH, COUNT_LOW
    } meas_phase_t;

    typedef struct packed {
        logic             right_a;
        logic             right_b;
        logic             left_a;
        logic             left_b;
        logic             aux;
        cmd_t             command;
        logic             done;
        logic [PER_W-1:0] period;
    } motor_out_t;

    typedef struct {
        bit                is_cfg;
        cfg_idx_t          idx;
        logic [RATE_W-1:0] val;
        logic              lvl;
        logic              pt;
        bit                typed;
        motor_out_t        want;
    } stim_row_t;

    logic aclk;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_signal_level = 1'b0;
    logic s_pwm_tick = 1'b0;
    logic m_ready = 1'b0;
    logic cfg_valid = 1'b0;
    logic [CIDX_W-1:0] cfg_index = '0;
    logic [RATE_W-1:0] cfg_data = '0;
    logic s_ready;
    logic m_valid;
    logic m_right_drive_a, m_right_drive_b, m_left_drive_a, m_left_drive_b;
    logic m_aux_drive;
    logic [2:0] m_active_command;
    logic m_measure_done;
    logic [31:0] m_period_ticks;
    logic cfg_ready;

    tone_command_motor_pwm_top #(
        .COUNT_WIDTH(CNT_W),
        .PWM_TOP    (PWM_MAX)
    ) uut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_signal_level  (s_signal_level),
        .s_pwm_tick      (s_pwm_tick),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_right_drive_a (m_right_drive_a),
        .m_right_drive_b (m_right_drive_b),
        .m_left_drive_a  (m_left_drive_a),
        .m_left_drive_b  (m_left_drive_b),
        .m_aux_drive     (m_aux_drive),
        .m_active_command(m_active_command),
        .m_measure_done  (m_measure_done),
        .m_period_ticks  (m_period_ticks),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    // predictor copy of configuration and state
    logic [FREQ_W-1:0] band_center [BANDS];
    logic [TOL_W-1:0]  tol_c;
    logic [RATE_W-1:0] rate_c;
    meas_phase_t       meas_st;
    logic [CNT_W-1:0]  tick_cnt;
    logic [CNT_W-1:0]  last_per;
    cmd_t              cmd_st;
    logic [6:0]        pwm_cnt;

    motor_out_t pending_outputs[$];
    int fail_count = 0;
    int tick_sent = 0;
    int quiet_cycles = 0;
    int gap_pct = 0;
    int stall_pct = 0;
    bit hold_req = 1'b0;
    bit offering = 1'b0;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic bit in_band(logic [FREQ_W-1:0] center, logic [CNT_W-1:0] per);
        logic [63:0] lo, hi, rate;
        rate = 64'(rate_c);
        lo = (center > 16'(tol_c)) ? 64'(center - 16'(tol_c)) : 64'd0;
        hi = 64'(center) + 64'(tol_c);
        return (lo * 64'(per) <= rate) && (rate <= hi * 64'(per));
    endfunction

    function automatic cmd_t classify(logic [CNT_W-1:0] per);
        if (in_band(band_center[0], per)) return CMD_RIGHT;
        if (in_band(band_center[1], per)) return CMD_FORWARD;
        if (in_band(band_center[2], per)) return CMD_BACKWARD;
        if (in_band(band_center[3], per)) return CMD_LEFT;
        return CMD_STOP;
    endfunction

    function automatic logic drive_bit(logic on);
        return 8'(pwm_cnt) <= (on ? 8'(PWM_ON) : 8'd0);
    endfunction

    function automatic motor_out_t motor_step(logic lvl, logic pt);
        motor_out_t r;
        r.done = 1'b0;
        case (meas_st)
            WAIT_LOW: if (!lvl) meas_st = WAIT_HIGH;
            WAIT_HIGH: if (lvl) begin
                tick_cnt = '0;
                meas_st = COUNT_HIGH;
            end
            COUNT_HIGH: begin
                if (tick_cnt != '1) tick_cnt++;
                if (!lvl) meas_st = COUNT_LOW;
            end
            default: begin
                if (tick_cnt != '1) tick_cnt++;
                if (lvl) begin
                    last_per = tick_cnt;
                    cmd_st = classify(tick_cnt);
                    r.done = 1'b1;
                    meas_st = WAIT_LOW;
                end
            end
        endcase
        if (pt) pwm_cnt = (pwm_cnt >= 7'(PWM_MAX)) ? 7'd0 : pwm_cnt + 7'd1;
        r.right_a = drive_bit(cmd_st == CMD_RIGHT || cmd_st == CMD_FORWARD);
        r.right_b = drive_bit(cmd_st == CMD_BACKWARD || cmd_st == CMD_LEFT);
        r.left_a  = drive_bit(cmd_st == CMD_RIGHT || cmd_st == CMD_BACKWARD);
        r.left_b  = drive_bit(cmd_st == CMD_FORWARD || cmd_st == CMD_LEFT);
        r.aux     = 8'(pwm_cnt) <= 8'(AUX_AT);
        r.command = cmd_st;
        r.period  = last_per[PER_W-1:0];
        return r;
    endfunction

    function automatic motor_out_t make_result(logic ra, logic rb, logic la, logic lb,
                                               logic aux, cmd_t c, logic d, int per);
        motor_out_t r;
        r = '{ra, rb, la, lb, aux, c, d, 32'(per)};
        return r;
    endfunction

    function automatic stim_row_t tick_row(logic lvl, logic pt);
        stim_row_t r;
        r = '{1'b0, CFG_RIGHT, '0, lvl, pt, 1'b0, '0};
        return r;
    endfunction

    function automatic stim_row_t checked_row(logic lvl, logic pt, motor_out_t want);
        stim_row_t r;
        r = '{1'b0, CFG_RIGHT, '0, lvl, pt, 1'b1, want};
        return r;
    endfunction

    function automatic stim_row_t reg_row(cfg_idx_t idx, int val);
        stim_row_t r;
        r = '{1'b1, idx, 27'(val), 1'b0, 1'b0, 1'b0, '0};
        return r;
    endfunction

    function automatic logic rand_ptick();
        return $urandom_range(0, 99) < 85;
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endfunction

    task automatic send_tick(logic lvl, logic pt, bit typed, motor_out_t want);
        motor_out_t p;
        while ($urandom_range(0, 99) < gap_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_signal_level <= lvl;
        s_pwm_tick <= pt;
        offering = 1'b1;
        do @(posedge aclk); while (!s_ready);
        p = motor_step(lvl, pt);
        pending_outputs.push_back(typed ? want : p);
        tick_sent++;
    endtask

    task automatic send_period(int lead, int hi_len, int lo_len);
        repeat (lead) send_tick(1'b0, rand_ptick(), 1'b0, '0);
        repeat (hi_len) send_tick(1'b1, rand_ptick(), 1'b0, '0);
        repeat (lo_len) send_tick(1'b0, rand_ptick(), 1'b0, '0);
        send_tick(1'b1, rand_ptick(), 1'b0, '0);
    endtask

    // stop offering and wait for every outstanding transaction to come back
    task automatic settle();
        if (offering) begin
            s_valid <= 1'b0;
            offering = 1'b0;
        end
        while (pending_outputs.size() != 0) @(posedge aclk);
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [RATE_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_RIGHT:    band_center[0] = val[FREQ_W-1:0];
            CFG_FORWARD:  band_center[1] = val[FREQ_W-1:0];
            CFG_BACKWARD: band_center[2] = val[FREQ_W-1:0];
            CFG_LEFT:     band_center[3] = val[FREQ_W-1:0];
            CFG_TOL:      tol_c = val[TOL_W-1:0];
            default:      rate_c = val;
        endcase
        @(posedge aclk);
    endtask

    // receiver side with random stalls and a long hold-off on request
    initial begin
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                hold_req = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= $urandom_range(0, 99) >= stall_pct;
            end
        end
    end

    // result checking and watchdog
    always @(posedge aclk) begin
        motor_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_outputs.size() == 0) begin
                $error("result transaction with no expectation waiting");
                fail_count++;
            end else begin
                want = pending_outputs.pop_front();
                check_field("right_drive_a", 32'(want.right_a), 32'(m_right_drive_a));
                check_field("right_drive_b", 32'(want.right_b), 32'(m_right_drive_b));
                check_field("left_drive_a", 32'(want.left_a), 32'(m_left_drive_a));
                check_field("left_drive_b", 32'(want.left_b), 32'(m_left_drive_b));
                check_field("aux_drive", 32'(want.aux), 32'(m_aux_drive));
                check_field("active_command", 32'(want.command), 32'(m_active_command));
                check_field("measure_done", 32'(want.done), 32'(m_measure_done));
                check_field("period_ticks", want.period, m_period_ticks);
            end
        end
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    initial begin
        stim_row_t directed[$];
        int budget[6];
        int vals[6];
        int rate, tol, total, hl, goal;

        band_center[0] = RIGHT_RST;
        band_center[1] = FORWARD_RST;
        band_center[2] = BACKWARD_RST;
        band_center[3] = LEFT_RST;
        tol_c = TOL_RST;
        rate_c = RATE_RST;
        meas_st = WAIT_LOW;
        tick_cnt = '0;
        last_per = '0;
        cmd_st = CMD_STOP;
        pwm_cnt = '0;

        directed = '{
            checked_row(1, 0, make_result(1, 1, 1, 1, 1, CMD_STOP, 0, 0)),
            checked_row(0, 0, make_result(1, 1, 1, 1, 1, CMD_STOP, 0, 0)),
            checked_row(1, 1, make_result(0, 0, 0, 0, 1, CMD_STOP, 0, 0)),
            tick_row(0, 1),
            // two tick period gives a tone far above every default band
            checked_row(1, 0, make_result(0, 0, 0, 0, 1, CMD_STOP, 1, 2)),
            reg_row(CFG_RATE, 12),
            reg_row(CFG_RIGHT, 3),
            reg_row(CFG_FORWARD, 4),
            reg_row(CFG_BACKWARD, 6),
            reg_row(CFG_LEFT, 2),
            reg_row(CFG_TOL, 0),
            // period 4 hits right exactly
            tick_row(0, 1), tick_row(1, 1), tick_row(0, 0),
            tick_row(0, 1), tick_row(0, 1), tick_row(1, 1),
            // period 3 hits forward
            tick_row(0, 1), tick_row(1, 0), tick_row(1, 1), tick_row(0, 1), tick_row(1, 1),
            // zero upper edge on right, falls through to backward
            reg_row(CFG_RIGHT, 0),
            tick_row(0, 1), tick_row(1, 1), tick_row(0, 1), tick_row(1, 0),
            // tolerance above center, lower test always passes
            reg_row(CFG_TOL, 4095),
            tick_row(0, 0), tick_row(1, 1), tick_row(0, 1), tick_row(1, 1)
        };
        budget = '{1, 140, 100, 60, 120, 140};

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        gap_pct = 23;
        stall_pct = 57;
        foreach (directed[i]) begin
            if (directed[i].is_cfg) begin
                settle();
                write_reg(directed[i].idx, directed[i].val);
            end else begin
                send_tick(directed[i].lvl, directed[i].pt, directed[i].typed, directed[i].want);
            end
        end

        for (int ph = 0; ph < 6; ph++) begin
            settle();
            case (ph % 3)
                0: begin gap_pct = 23; stall_pct = 57; end
                1: begin gap_pct = 57; stall_pct = 23; end
                default: begin gap_pct = 0; stall_pct = 0; end
            endcase
            rate = $urandom_range(24, 600);
            tol = $urandom_range(0, 4);
            for (int b = 0; b < BANDS; b++) vals[b] = rate / $urandom_range(2, 12);
            vals[4] = tol;
            vals[5] = rate;
            case (ph)
                0: vals = '{RIGHT_RST, FORWARD_RST, BACKWARD_RST, LEFT_RST, TOL_RST, RATE_RST};
                2: vals = '{0, 65535, 0, 65535, 0, 1};
                3: vals = '{65535, 0, 65535, 0, 4095, 100000000};
                4: begin
                    // narrow right band with its lower edge below zero
                    vals[4] = $urandom_range(1, 8);
                    vals[0] = $urandom_range(0, vals[4] - 1);
                    vals[5] = $urandom_range(24, 200);
                end
                default: ;
            endcase
            for (int i = 0; i < 6; i++) write_reg(cfg_idx_t'(i), 27'(vals[i]));
            if (ph == 2) hold_req = 1'b1;
            goal = tick_sent + budget[ph];
            while (tick_sent < goal) begin
                if (ph == 0) begin
                    total = $urandom_range(398, 414);
                    hl = $urandom_range(150, 250);
                    send_period($urandom_range(1, 3), hl, total - hl);
                end else if ($urandom_range(0, 99) < 15) begin
                    repeat ($urandom_range(1, 8))
                        send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1'b0, '0);
                end else begin
                    send_period($urandom_range(1, 3), $urandom_range(1, 6), $urandom_range(1, 6));
                end
            end
        end

        settle();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
